[rtl/rtae_pkg.sv]
// Shared types, codes and constants of the route table aging engine.
package rtae_pkg;

  // Field widths fixed by the item layout
  localparam int unsigned FuncW   = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned MetricW = 8;
  localparam int unsigned IfaceW  = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ExpireW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 112;

  // Defaults
  localparam int unsigned DefEntries   = 32;
  localparam int unsigned DefIfaces    = 8;
  localparam int unsigned MaxResults   = 32;
  localparam logic [MetricW-1:0] InfReset    = 8'd16;
  localparam logic [ExpireW-1:0] ExpireReset = 16'd20;

  // Request function codes
  localparam logic [FuncW-1:0] FuncClear  = 3'd0;
  localparam logic [FuncW-1:0] FuncAdd    = 3'd1;
  localparam logic [FuncW-1:0] FuncAge    = 3'd2;
  localparam logic [FuncW-1:0] FuncIface  = 3'd3;
  localparam logic [FuncW-1:0] FuncExport = 3'd4;

  // Result status codes
  localparam logic [StatusW-1:0] StDone     = 2'd0;
  localparam logic [StatusW-1:0] StDropped  = 2'd1;
  localparam logic [StatusW-1:0] StExported = 2'd2;
  localparam logic [StatusW-1:0] StNone     = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgInfinity = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpire   = 2'd1;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_AGE,
    OP_IFDOWN,
    OP_IFUP,
    OP_EXPORT,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               if_ok;
    logic [AddrW-1:0]   now;
    logic [AddrW-1:0]   dest;
    logic [AddrW-1:0]   mask;
    logic [AddrW-1:0]   gw;
    logic [MetricW-1:0] metric;
    logic [IfaceW-1:0]  iface;
  } cmd_t;

endpackage

[rtl/rtae_front.sv]
// Request intake: decodes each request and queues it for the table engine.
module rtae_front #(
  parameter int unsigned IFACES = rtae_pkg::DefIfaces
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // now, dest, mask, gateway, metric, iface, up (from bit 0 up)
  input  logic [rtae_pkg::InDataW-1:0] s_axis_tdata_i,
  // func
  input  logic [rtae_pkg::FuncW-1:0]   s_axis_tuser_i,
  output rtae_pkg::cmd_t               cmd_o,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i
);
  import rtae_pkg::*;

  localparam int unsigned IfCmpW = IfaceW + 2;

  cmd_t       cmd;
  logic       up;
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  // Unpack and classify the request
  always_comb begin
    cmd.now    = s_axis_tdata_i[31:0];
    cmd.dest   = s_axis_tdata_i[63:32];
    cmd.mask   = s_axis_tdata_i[95:64];
    cmd.gw     = s_axis_tdata_i[127:96];
    cmd.metric = s_axis_tdata_i[135:128];
    cmd.iface  = s_axis_tdata_i[138:136];
    up         = s_axis_tdata_i[139];
    cmd.if_ok  = IfCmpW'(cmd.iface) < IfCmpW'(IFACES);
    unique case (s_axis_tuser_i)
      FuncClear:  cmd.op = OP_CLEAR;
      FuncAdd:    cmd.op = OP_ADD;
      FuncAge:    cmd.op = OP_AGE;
      FuncIface:  cmd.op = !cmd.if_ok ? OP_NOP : (up ? OP_IFUP : OP_IFDOWN);
      FuncExport: cmd.op = OP_EXPORT;
      default:    cmd.op = OP_NOP;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign pop             = cmd_valid_o && cmd_ready_i;
  assign cmd_o           = fifo_q[rd_ptr_q];

  // Hold decoded requests in a two-deep queue
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd;
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/rtae_back.sv]
// Table engine: route stores, entry walk sequencer and result register.
module rtae_back #(
  parameter int unsigned ENTRIES = rtae_pkg::DefEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rtae_pkg::MetricW-1:0]     infinity_i,
  input  logic [rtae_pkg::ExpireW-1:0]     expire_i,
  input  rtae_pkg::cmd_t                   cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rtae_pkg::StatusW-1:0]     out_status_o,
  output logic [rtae_pkg::AddrW-1:0]       out_dest_o,
  output logic [rtae_pkg::AddrW-1:0]       out_mask_o,
  output logic [rtae_pkg::AddrW-1:0]       out_nh_o,
  output logic [rtae_pkg::MetricW-1:0]     out_metric_o,
  output logic                             out_last_o
);
  import rtae_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_REPORT, ST_FLUSH} state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic [CW-1:0]      count_q, rd_ptr_q;
  logic [AW-1:0]      s1_idx_q;
  logic               s1_vld_q, found_q, pend_vld_q;
  logic [KW-1:0]      k_q;
  logic [StatusW-1:0] st_q;

  // Route stores
  logic [AddrW-1:0]   dest_mem [ENTRIES];
  logic [AddrW-1:0]   mask_mem [ENTRIES];
  logic [AddrW-1:0]   nh_mem   [ENTRIES];
  logic [IfaceW-1:0]  if_mem   [ENTRIES];
  logic [MetricW-1:0] met_mem  [ENTRIES];
  logic [AddrW-1:0]   stamp_mem[ENTRIES];

  logic [AddrW-1:0]   rd_dest_q, rd_mask_q, rd_nh_q, rd_stamp_q;
  logic [IfaceW-1:0]  rd_if_q;
  logic [MetricW-1:0] rd_met_q;

  logic [AddrW-1:0]   pend_dest_q, pend_mask_q, pend_nh_q;
  logic [MetricW-1:0] pend_met_q;

  logic               out_vld_q, out_last_q;
  logic [StatusW-1:0] out_st_q;
  logic [AddrW-1:0]   out_dest_q, out_mask_q, out_nh_q;
  logic [MetricW-1:0] out_met_q;

  logic out_free, full, age_hit, if_hit, up_hit, exp_hit;
  logic s1_ok, s1_go, adv, rd_en, walk_end, pop, out_load;

  // Write port
  logic               we_dest, we_mask, we_nh, we_if, we_met, we_stamp;
  logic [AW-1:0]      wr_addr;
  logic [AddrW-1:0]   wr_dest, wr_mask, wr_nh, wr_stamp;
  logic [IfaceW-1:0]  wr_if;
  logic [MetricW-1:0] wr_met;

  // Classify the entry in the compare stage
  always_comb begin
    out_free = !out_vld_q || out_ready_i;
    full     = (count_q >= CW'(ENTRIES));
    age_hit  = (cmd_q.now - rd_stamp_q) > {{(AddrW-ExpireW){1'b0}}, expire_i};
    if_hit   = (rd_if_q == cmd_q.iface);
    up_hit   = ((rd_dest_q & rd_mask_q) == (cmd_q.dest & cmd_q.mask)) &&
               (rd_mask_q == cmd_q.mask);
    exp_hit  = !if_hit && (k_q < KW'(MaxResults));
    s1_ok    = !((cmd_q.op == OP_EXPORT) && exp_hit && pend_vld_q && !out_free);
    s1_go    = (state_q == ST_WALK) && s1_vld_q && s1_ok;
    adv      = !s1_vld_q || s1_ok;
    rd_en    = (state_q == ST_WALK) && adv && (rd_ptr_q < count_q);
    walk_end = (state_q == ST_WALK) && !s1_vld_q && (rd_ptr_q == count_q);
    pop      = (state_q == ST_IDLE) && cmd_valid_i;
    out_load = (s1_go && (cmd_q.op == OP_EXPORT) && exp_hit && pend_vld_q) ||
               (((state_q == ST_REPORT) || (state_q == ST_FLUSH)) && out_free);
  end

  assign cmd_ready_o = (state_q == ST_IDLE);

  // Select the store write: append or update of the entry in the compare stage
  always_comb begin
    we_dest = 1'b0; we_mask = 1'b0; we_nh = 1'b0;
    we_if = 1'b0; we_met = 1'b0; we_stamp = 1'b0;
    wr_addr  = count_q[AW-1:0];
    wr_dest  = cmd_i.dest;
    wr_mask  = cmd_i.mask;
    wr_nh    = cmd_i.gw;
    wr_if    = cmd_i.iface;
    wr_met   = cmd_i.metric;
    wr_stamp = cmd_i.now;
    if (pop && (cmd_i.op == OP_ADD) && cmd_i.if_ok && !full) begin
      {we_dest, we_mask, we_nh, we_if, we_met, we_stamp} = '1;
    end else if (walk_end && (cmd_q.op == OP_IFUP) && !found_q && !full) begin
      {we_dest, we_mask, we_nh, we_if, we_met, we_stamp} = '1;
      wr_dest  = cmd_q.dest;
      wr_mask  = cmd_q.mask;
      wr_nh    = '0;
      wr_if    = cmd_q.iface;
      wr_met   = '0;
      wr_stamp = cmd_q.now;
    end else if (s1_go) begin
      wr_addr  = s1_idx_q;
      wr_nh    = '0;
      wr_if    = cmd_q.iface;
      wr_met   = infinity_i;
      wr_stamp = cmd_q.now;
      unique case (cmd_q.op)
        OP_AGE:    we_met = age_hit;
        OP_IFDOWN: we_met = if_hit;
        OP_IFUP: begin
          we_met   = up_hit;
          we_nh    = up_hit;
          we_if    = up_hit;
          we_stamp = up_hit;
          wr_met   = '0;
        end
        default: we_met = 1'b0;
      endcase
    end
  end

  // Write and read the route stores
  always_ff @(posedge clk_i) begin
    if (we_dest)  dest_mem[wr_addr]  <= wr_dest;
    if (we_mask)  mask_mem[wr_addr]  <= wr_mask;
    if (we_nh)    nh_mem[wr_addr]    <= wr_nh;
    if (we_if)    if_mem[wr_addr]    <= wr_if;
    if (we_met)   met_mem[wr_addr]   <= wr_met;
    if (we_stamp) stamp_mem[wr_addr] <= wr_stamp;
    if (rd_en) begin
      rd_dest_q  <= dest_mem[rd_ptr_q[AW-1:0]];
      rd_mask_q  <= mask_mem[rd_ptr_q[AW-1:0]];
      rd_nh_q    <= nh_mem[rd_ptr_q[AW-1:0]];
      rd_if_q    <= if_mem[rd_ptr_q[AW-1:0]];
      rd_met_q   <= met_mem[rd_ptr_q[AW-1:0]];
      rd_stamp_q <= stamp_mem[rd_ptr_q[AW-1:0]];
    end
  end

  // Sequence requests, walk the table and drive the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_ptr_q   <= '0;
      s1_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      k_q        <= '0;
      st_q       <= StDone;
      out_vld_q  <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q      <= cmd_i;
            rd_ptr_q   <= '0;
            s1_vld_q   <= 1'b0;
            found_q    <= 1'b0;
            pend_vld_q <= 1'b0;
            k_q        <= '0;
            st_q       <= ((cmd_i.op == OP_ADD) && !(cmd_i.if_ok && !full)) ?
                          StDropped : StDone;
            unique case (cmd_i.op)
              OP_CLEAR: begin
                count_q <= '0;
                state_q <= ST_REPORT;
              end
              OP_ADD: begin
                if (cmd_i.if_ok && !full) count_q <= count_q + 1'b1;
                state_q <= ST_REPORT;
              end
              OP_AGE, OP_IFDOWN, OP_IFUP, OP_EXPORT: state_q <= ST_WALK;
              default: state_q <= ST_REPORT;
            endcase
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
            s1_vld_q <= 1'b1;
            s1_idx_q <= rd_ptr_q[AW-1:0];
          end else if (adv) begin
            s1_vld_q <= 1'b0;
          end
          if (s1_go && (cmd_q.op == OP_IFUP) && up_hit) found_q <= 1'b1;
          if (s1_go && (cmd_q.op == OP_EXPORT) && exp_hit) begin
            if (pend_vld_q) begin
              out_vld_q  <= 1'b1;
              out_st_q   <= StExported;
              out_dest_q <= pend_dest_q;
              out_mask_q <= pend_mask_q;
              out_nh_q   <= pend_nh_q;
              out_met_q  <= pend_met_q;
              out_last_q <= 1'b0;
            end
            pend_vld_q  <= 1'b1;
            pend_dest_q <= rd_dest_q;
            pend_mask_q <= rd_mask_q;
            pend_nh_q   <= rd_nh_q;
            pend_met_q  <= rd_met_q;
            k_q         <= k_q + 1'b1;
          end
          if (walk_end) begin
            state_q <= ((cmd_q.op == OP_EXPORT) && pend_vld_q) ? ST_FLUSH : ST_REPORT;
            if (cmd_q.op == OP_IFUP && !found_q) begin
              if (!full) count_q <= count_q + 1'b1;
              else st_q <= StDropped;
            end else if ((cmd_q.op == OP_EXPORT) && !pend_vld_q) begin
              st_q <= StNone;
            end
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_st_q   <= st_q;
            out_dest_q <= '0;
            out_mask_q <= '0;
            out_nh_q   <= '0;
            out_met_q  <= '0;
            out_last_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_st_q   <= StExported;
            out_dest_q <= pend_dest_q;
            out_mask_q <= pend_mask_q;
            out_nh_q   <= pend_nh_q;
            out_met_q  <= pend_met_q;
            out_last_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_dest_o   = out_dest_q;
  assign out_mask_o   = out_mask_q;
  assign out_nh_o     = out_nh_q;
  assign out_metric_o = out_met_q;
  assign out_last_o   = out_last_q;

endmodule

[rtl/route_table_aging_engine_unit.sv]
// Top level of the route table aging engine: config registers, intake and table engine.
//
//  Channel | Direction | Handshake              | Payload
//  s_axis  | in        | tvalid / tready        | tdata: request fields, tuser: func
//  m_axis  | out       | tvalid / tready        | tdata: result fields, tlast: last
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Clear, add and unused codes go from the queue head through ST_REPORT to the result register.
// Age sweep, interface check and export walk the stored entries through one store
// read port, one entry a cycle while the walk is not stalled.
// Export stalls its walk while the result register is held by the sink.
// Reset empties the table at once; no clearing pass is needed.
// A two-deep request queue lets intake continue while the engine works.
module route_table_aging_engine_unit #(
  parameter int unsigned ENTRIES = rtae_pkg::DefEntries,
  parameter int unsigned IFACES  = rtae_pkg::DefIfaces
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_seconds, route_dest, route_mask, route_gateway, route_metric,
  // iface_index, iface_up (from bit 0 up, zero padded)
  input  logic [rtae_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func
  input  logic [rtae_pkg::FuncW-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status, entry_dest, entry_mask, entry_hop, entry_metric
  // (from bit 0 up, zero padded)
  output logic [rtae_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtae_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtae_pkg::CfgDataW-1:0] cfg_data_i
);
  import rtae_pkg::*;

  logic [MetricW-1:0] infinity_q;
  logic [ExpireW-1:0] expire_q;
  cmd_t               cmd;
  logic               cmd_valid, cmd_ready;
  logic [StatusW-1:0] out_status;
  logic [AddrW-1:0]   out_dest, out_mask, out_nh;
  logic [MetricW-1:0] out_metric;

  // Hold configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infinity_q <= InfReset;
      expire_q   <= ExpireReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgInfinity) infinity_q <= cfg_data_i[MetricW-1:0];
      if (cfg_index_i == CfgExpire)   expire_q   <= cfg_data_i[ExpireW-1:0];
    end
  end

  rtae_front #(.IFACES(IFACES)) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  rtae_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i,
    .rst_ni,
    .infinity_i   (infinity_q),
    .expire_i     (expire_q),
    .cmd_i        (cmd),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_dest_o   (out_dest),
    .out_mask_o   (out_mask),
    .out_nh_o     (out_nh),
    .out_metric_o (out_metric),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the result
  assign m_axis_tdata_o = {6'd0, out_metric, out_nh, out_mask, out_dest, out_status};

endmodule

[rtl/rtae_checker.sv]
// Port-level checks of the route table aging engine, bound to its top level.
module rtae_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rtae_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tlast_o
);
  import rtae_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only exported entries may continue a run
  a_mid_is_export: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[1:0] == StExported)
    else $error("non-export result without last");

  // Non-export results carry no entry
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != StExported |->
      m_axis_tdata_o[OutDataW-1:StatusW] == '0)
    else $error("status result with nonzero entry");

endmodule

bind route_table_aging_engine_unit rtae_checker u_rtae_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o,
  .m_axis_tlast_o
);

[verif/route_table_aging_engine_unit_tb.sv]
// Self-checking testbench of the route table aging engine with a scoreboard class.
`timescale 1ns / 1ps

module route_table_aging_engine_unit_tb;
  import rtae_pkg::*;

  localparam int unsigned NumEntries = 32;
  localparam int unsigned NumIfaces  = 8;
  localparam int unsigned NumRandom  = 184;
  localparam int unsigned IdleLimit  = 20000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   dest;
    logic [AddrW-1:0]   mask;
    logic [AddrW-1:0]   hop;
    logic [MetricW-1:0] metric;
    logic               last;
  } route_result_t;

  typedef struct {
    logic [FuncW-1:0]   func;
    logic [AddrW-1:0]   now;
    logic [AddrW-1:0]   dest;
    logic [AddrW-1:0]   mask;
    logic [AddrW-1:0]   gw;
    logic [MetricW-1:0] metric;
    logic [IfaceW-1:0]  iface;
    logic               up;
  } route_req_t;

  // Scoreboard: mirrors the route table and queues the expected results
  class route_table_scoreboard;
    logic [MetricW-1:0] inf_metric;
    logic [ExpireW-1:0] expire;
    int unsigned        count;
    logic [AddrW-1:0]   dest_tbl[NumEntries];
    logic [AddrW-1:0]   mask_tbl[NumEntries];
    logic [AddrW-1:0]   hop_tbl[NumEntries];
    logic [IfaceW-1:0]  iface_tbl[NumEntries];
    logic [MetricW-1:0] metric_tbl[NumEntries];
    logic [AddrW-1:0]   stamp_tbl[NumEntries];
    route_result_t      pending[$];
    int unsigned        errors;

    function void init();
      inf_metric = InfReset;
      expire = ExpireReset;
      count = 0;
      errors = 0;
    endfunction

    function bit append(route_req_t r, logic [AddrW-1:0] hop, logic [MetricW-1:0] met);
      if (count >= NumEntries) return 0;
      dest_tbl[count] = r.dest;
      mask_tbl[count] = r.mask;
      hop_tbl[count] = hop;
      iface_tbl[count] = r.iface;
      metric_tbl[count] = met;
      stamp_tbl[count] = r.now;
      count++;
      return 1;
    endfunction

    function void note_request(route_req_t r);
      route_result_t res;
      logic [StatusW-1:0] st;
      bit found;
      int k;
      st = StDone;
      k = 0;
      case (r.func)
        FuncClear: count = 0;
        FuncAdd: begin
          if (r.iface >= NumIfaces || !append(r, r.gw, r.metric)) st = StDropped;
        end
        FuncAge: begin
          for (int i = 0; i < count; i++)
            if (AddrW'(r.now - stamp_tbl[i]) > {16'd0, expire}) metric_tbl[i] = inf_metric;
        end
        FuncIface: begin
          if (r.iface < NumIfaces) begin
            if (!r.up) begin
              for (int i = 0; i < count; i++)
                if (iface_tbl[i] == r.iface) metric_tbl[i] = inf_metric;
            end else begin
              found = 0;
              for (int i = 0; i < count; i++)
                if ((dest_tbl[i] & mask_tbl[i]) == (r.dest & r.mask) &&
                    mask_tbl[i] == r.mask) begin
                  stamp_tbl[i] = r.now;
                  metric_tbl[i] = '0;
                  hop_tbl[i] = '0;
                  iface_tbl[i] = r.iface;
                  found = 1;
                end
              if (!found && !append(r, '0, '0)) st = StDropped;
            end
          end
        end
        FuncExport: begin
          for (int i = 0; i < count && k < MaxResults; i++)
            if (iface_tbl[i] != r.iface) begin
              res = '{StExported, dest_tbl[i], mask_tbl[i], hop_tbl[i], metric_tbl[i], 1'b0};
              pending.push_back(res);
              k++;
            end
          if (k > 0) begin
            pending[$].last = 1'b1;
            return;
          end
          st = StNone;
        end
        default: ;
      endcase
      res = '{st, '0, '0, '0, '0, 1'b1};
      pending.push_back(res);
    endfunction

    function void check_result(route_result_t got);
      route_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: st %0d/%0d dest %h/%h mask %h/%h hop %h/%h met %0d/%0d last %b/%b",
                   want.status, got.status, want.dest, got.dest, want.mask, got.mask,
                   want.hop, got.hop, want.metric, got.metric, want.last, got.last);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i = '0;
  logic [FuncW-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  route_table_scoreboard route_sb;
  bit          quiet_tail;
  int unsigned idle_cycles = 0;
  logic [AddrW-1:0] clock_now;
  route_req_t  req;

  route_table_aging_engine_unit uut (.*);

  always #10 clk_i = ~clk_i;

  // Sink: random stall bursts, check every accepted result
  initial begin
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        route_sb.check_result({m_axis_tlast_o, m_axis_tdata_o[105:0]} == 0 ? '0 :
          route_result_t'{m_axis_tdata_o[1:0], m_axis_tdata_o[33:2], m_axis_tdata_o[65:34],
                          m_axis_tdata_o[97:66], m_axis_tdata_o[105:98], m_axis_tlast_o});
      if (burst > 0) begin
        burst--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 12);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Hold valid between back-to-back requests; drop it only for an idle burst
  task automatic send_request(route_req_t r);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.func;
    s_axis_tdata_i  <= {4'd0, r.up, r.iface, r.metric, r.gw, r.mask, r.dest, r.now};
    do @(posedge clk_i); while (!s_axis_tready_o);
    route_sb.note_request(r);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (route_sb.pending.size() != 0) @(posedge clk_i);
    repeat (NumEntries + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgInfinity) route_sb.inf_metric = val[MetricW-1:0];
    else route_sb.expire = val;
  endtask

  // Build one request; addresses drawn from a small pool so subnets match
  function automatic route_req_t make_request(logic [FuncW-1:0] f);
    route_req_t r;
    logic [AddrW-1:0] masks[4] = '{32'hFFFFFF00, 32'hFFFF0000, 32'hFFFFFFFF, 32'h0};
    r.func = f;
    clock_now = clock_now + $urandom_range(0, 12);
    r.now = ($urandom_range(0, 30) == 0) ? $urandom : clock_now;
    r.dest = ($urandom_range(0, 3) == 0) ? $urandom : {8'd10, 8'($urandom_range(0, 3)),
                                                       8'($urandom_range(0, 3)), 8'($urandom)};
    r.mask = ($urandom_range(0, 5) == 0) ? $urandom : masks[$urandom_range(0, 3)];
    r.gw = $urandom;
    r.metric = 8'($urandom);
    r.iface = 3'($urandom_range(0, 7));
    r.up = 1'($urandom);
    return r;
  endfunction

  initial begin
    route_sb = new();
    route_sb.init();
    quiet_tail = 0;
    clock_now = 32'hFFFF_FF00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every function, full table, interface cases
    req = make_request(FuncExport);
    send_request(req);
    req = make_request(FuncAdd);
    req.dest = '1; req.mask = '1; req.gw = '1; req.metric = '1; req.iface = 3'd7;
    req.now = '1;
    send_request(req);
    req = make_request(FuncAdd);
    req.dest = '0; req.mask = '0; req.gw = '0; req.metric = '0; req.iface = 3'd0;
    req.now = '0;
    send_request(req);
    req = make_request(FuncIface); req.up = 1'b1; req.iface = 3'd2; send_request(req);
    req = make_request(FuncIface); req.up = 1'b0; req.iface = 3'd7; send_request(req);
    req = make_request(FuncAge); req.now = 32'd40; send_request(req);
    req = make_request(FuncExport); req.iface = 3'd0; send_request(req);
    req = make_request(3'd5); send_request(req);
    req = make_request(3'd7); send_request(req);
    for (int i = 0; i < NumEntries + 2; i++) begin
      req = make_request(FuncAdd);
      req.iface = 3'((i % 3) + 1);
      send_request(req);
    end
    req = make_request(FuncIface); req.up = 1'b1; req.dest = 32'hC0A8_0101;
    req.mask = 32'hFFFF_FFFF; send_request(req);
    req = make_request(FuncExport); req.iface = 3'd5; send_request(req);
    req = make_request(FuncClear); send_request(req);
    drain();

    // Register settings across phases, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(CfgInfinity, 16'd1); write_reg(CfgExpire, 16'd0); end
        1: begin write_reg(CfgInfinity, 16'd255); write_reg(CfgExpire, 16'hFFFF); end
        2: begin write_reg(CfgInfinity, 16'($urandom_range(1, 255)));
                 write_reg(CfgExpire, 16'($urandom_range(0, 60))); end
        default: begin write_reg(CfgInfinity, 16'd16); write_reg(CfgExpire, 16'd20); end
      endcase
      cfg_valid_i <= 1'b0;
      if (phase == 3) quiet_tail = 1;
      for (int n = 0; n < NumRandom / 4; n++) begin
        case ($urandom_range(0, 19))
          0: req = make_request(FuncClear);
          1, 2, 3, 4, 5, 6: req = make_request(FuncAdd);
          7, 8, 9: req = make_request(FuncAge);
          10, 11, 12, 13: req = make_request(FuncIface);
          14, 15, 16, 17: req = make_request(FuncExport);
          default: req = make_request(3'($urandom_range(5, 7)));
        endcase
        send_request(req);
        if (n == 20 && phase == 1) drain();
      end
      drain();
    end

    if (route_sb.errors == 0 && route_sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
